FILE: rtl/core/cbs_pkg.sv
// ============================================================================
// cbs_pkg - shared constants and types for the cubic Bezier splitter
// Default widths, queue depth, result indexing and the back-end state codes.
// ============================================================================
package cbs_pkg;

    localparam int COORD_BITS_DEF  = 32;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int NUM_AXES  = 2;
    localparam int NUM_CTRL  = 4;
    localparam int NUM_LANES = 3;
    localparam int NUM_PTS   = 7;
    localparam int IDX_BITS  = 3;

    localparam logic [IDX_BITS-1:0] IDX_FIRST = 3'd0;
    localparam logic [IDX_BITS-1:0] IDX_LAST  = 3'd6;

    typedef enum logic [1:0] {
        CMP_IDLE,
        CMP_MUL,
        CMP_ADD,
        CMP_DONE
    } cmp_state_t;

    typedef enum logic [1:0] {
        LVL_1,
        LVL_2,
        LVL_3
    } level_t;

endpackage

FILE: rtl/core/cbs_front.sv
// ============================================================================
// cbs_front - request intake
// Registers one request, clamps t to 1.0 and flags the exact one-half split.
// ============================================================================
module cbs_front #(
    parameter int COORD_BITS  = cbs_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = cbs_pkg::T_FRAC_BITS_DEF,
    parameter int QW          = 8 * COORD_BITS + T_FRAC_BITS + 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_p0_x,
    input  logic signed [COORD_BITS-1:0]  s_p0_y,
    input  logic signed [COORD_BITS-1:0]  s_p1_x,
    input  logic signed [COORD_BITS-1:0]  s_p1_y,
    input  logic signed [COORD_BITS-1:0]  s_p2_x,
    input  logic signed [COORD_BITS-1:0]  s_p2_y,
    input  logic signed [COORD_BITS-1:0]  s_p3_x,
    input  logic signed [COORD_BITS-1:0]  s_p3_y,
    input  logic        [T_FRAC_BITS:0]   s_split_t,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic        [QW-1:0]          q_data
);

    localparam logic [T_FRAC_BITS:0] T_ONE  = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [T_FRAC_BITS:0] T_HALF = {2'b01, {(T_FRAC_BITS-1){1'b0}}};

    logic                        valid_reg, valid_next;
    logic [8*COORD_BITS-1:0]     pts_reg;
    logic [T_FRAC_BITS:0]        t_reg;
    logic                        half_reg;
    logic [T_FRAC_BITS:0]        t_sat;
    logic                        s_fire;

    assign s_ready = !valid_reg || q_ready;
    assign s_fire  = s_valid && s_ready;

    assign t_sat = (s_split_t[T_FRAC_BITS] && (|s_split_t[T_FRAC_BITS-1:0]))
                   ? T_ONE : s_split_t;

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pts_reg  <= {s_p3_y, s_p3_x, s_p2_y, s_p2_x, s_p1_y, s_p1_x, s_p0_y, s_p0_x};
            t_reg    <= t_sat;
            half_reg <= (t_sat == T_HALF);
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = {half_reg, t_reg, pts_reg};

endmodule

FILE: rtl/core/cbs_fifo.sv
// ============================================================================
// cbs_fifo - short request queue
// Flop-based FIFO between the intake and the compute back end.
// ============================================================================
module cbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != CNT_MAX);
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/cbs_back.sv
// ============================================================================
// cbs_back - de Casteljau compute and result serializer
// Three lerp lanes per axis run the three levels (multiply, then add), and a
// seven-slot shift register sends the points while the next curve computes.
// ============================================================================
module cbs_back #(
    parameter int COORD_BITS  = cbs_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = cbs_pkg::T_FRAC_BITS_DEF,
    parameter int QW          = 8 * COORD_BITS + T_FRAC_BITS + 2
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  logic [QW-1:0]                        q_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [cbs_pkg::IDX_BITS-1:0]         m_point_index,
    output logic signed [COORD_BITS-1:0]         m_out_x,
    output logic signed [COORD_BITS-1:0]         m_out_y,
    output logic                                 m_last
);

    localparam int C  = COORD_BITS;
    localparam int T  = T_FRAC_BITS;
    localparam int PW = C + T + 3;
    localparam int HW = C + 3;
    localparam int NA = cbs_pkg::NUM_AXES;
    localparam int NC = cbs_pkg::NUM_CTRL;
    localparam int NL = cbs_pkg::NUM_LANES;
    localparam int NP = cbs_pkg::NUM_PTS;

    cbs_pkg::cmp_state_t state_reg, state_next;
    cbs_pkg::level_t     level_reg, level_next;

    logic signed [C-1:0]  c_reg    [NA][NC];
    logic        [T:0]    t_reg;
    logic                 half_reg;

    logic signed [C-1:0]  la_reg   [NA][NL];
    logic signed [PW-1:0] lp_reg   [NA][NL];

    logic signed [C-1:0]  ab_reg   [NA];
    logic signed [C-1:0]  bc_reg   [NA];
    logic signed [C-1:0]  cd_reg   [NA];
    logic signed [C-1:0]  abc_reg  [NA];
    logic signed [C-1:0]  bcd_reg  [NA];
    logic signed [C-1:0]  abcd_reg [NA];

    logic signed [C-1:0]  ox_reg   [NP];
    logic signed [C-1:0]  oy_reg   [NP];
    logic                 ovalid_reg, ovalid_next;
    logic [cbs_pkg::IDX_BITS-1:0] idx_reg, idx_next;

    logic                 out_free, load, pop, m_fire, is_last;
    logic signed [C-1:0]  op_a     [NA][NL];
    logic signed [C-1:0]  op_b     [NA][NL];
    logic signed [PW-1:0] prod     [NA][NL];
    logic signed [C-1:0]  lsum     [NA][NL];
    logic signed [C-1:0]  res      [NA][NP];

    assign is_last  = (idx_reg == cbs_pkg::IDX_LAST);
    assign m_fire   = ovalid_reg && m_ready;
    assign out_free = !ovalid_reg || (m_ready && is_last);

    // next state
    always_comb begin
        state_next = state_reg;
        level_next = level_reg;
        unique case (state_reg)
            cbs_pkg::CMP_IDLE: begin
                if (q_valid) begin
                    state_next = cbs_pkg::CMP_MUL;
                    level_next = cbs_pkg::LVL_1;
                end
            end
            cbs_pkg::CMP_MUL: begin
                state_next = cbs_pkg::CMP_ADD;
            end
            cbs_pkg::CMP_ADD: begin
                if (level_reg == cbs_pkg::LVL_3) begin
                    state_next = cbs_pkg::CMP_DONE;
                end else begin
                    state_next = cbs_pkg::CMP_MUL;
                    level_next = (level_reg == cbs_pkg::LVL_1) ? cbs_pkg::LVL_2
                                                               : cbs_pkg::LVL_3;
                end
            end
            cbs_pkg::CMP_DONE: begin
                if (out_free) begin
                    if (q_valid) begin
                        state_next = cbs_pkg::CMP_MUL;
                        level_next = cbs_pkg::LVL_1;
                    end else begin
                        state_next = cbs_pkg::CMP_IDLE;
                    end
                end
            end
            default: begin
                state_next = cbs_pkg::CMP_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_ready = 1'b0;
        load    = 1'b0;
        unique case (state_reg)
            cbs_pkg::CMP_IDLE: begin
                q_ready = 1'b1;
            end
            cbs_pkg::CMP_DONE: begin
                q_ready = out_free;
                load    = out_free;
            end
            default: begin
                q_ready = 1'b0;
            end
        endcase
    end

    assign pop = q_valid && q_ready;

    // lane operands, products and sums
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            unique case (level_reg)
                cbs_pkg::LVL_1: begin
                    op_a[a][0] = c_reg[a][0];
                    op_b[a][0] = c_reg[a][1];
                    op_a[a][1] = c_reg[a][1];
                    op_b[a][1] = c_reg[a][2];
                end
                cbs_pkg::LVL_2: begin
                    op_a[a][0] = ab_reg[a];
                    op_b[a][0] = bc_reg[a];
                    op_a[a][1] = bc_reg[a];
                    op_b[a][1] = cd_reg[a];
                end
                default: begin
                    op_a[a][0] = abc_reg[a];
                    op_b[a][0] = bcd_reg[a];
                    op_a[a][1] = bc_reg[a];
                    op_b[a][1] = cd_reg[a];
                end
            endcase
            op_a[a][2] = c_reg[a][2];
            op_b[a][2] = c_reg[a][3];
        end
    end

    always_comb begin
        logic signed [C:0]    diff;
        logic signed [PW-1:0] shifted;
        for (int a = 0; a < NA; a++) begin
            for (int l = 0; l < NL; l++) begin
                diff       = {op_b[a][l][C-1], op_b[a][l]} - {op_a[a][l][C-1], op_a[a][l]};
                prod[a][l] = diff * $signed({1'b0, t_reg});
                shifted    = lp_reg[a][l] >>> T;
                lsum[a][l] = la_reg[a][l] + shifted[C-1:0];
            end
        end
    end

    // result set, with the exact midpoint sums for t of one half
    always_comb begin
        logic signed [HW-1:0] e0, e1, e2, e3, s12, h1, h2, h3, h4, h5;
        for (int a = 0; a < NA; a++) begin
            e0  = {{3{c_reg[a][0][C-1]}}, c_reg[a][0]};
            e1  = {{3{c_reg[a][1][C-1]}}, c_reg[a][1]};
            e2  = {{3{c_reg[a][2][C-1]}}, c_reg[a][2]};
            e3  = {{3{c_reg[a][3][C-1]}}, c_reg[a][3]};
            s12 = e1 + e2;
            h1  = (e0 + e1) >>> 1;
            h2  = (e0 + (e1 <<< 1) + e2) >>> 2;
            h3  = (e0 + s12 + (s12 <<< 1) + e3) >>> 3;
            h4  = (e1 + (e2 <<< 1) + e3) >>> 2;
            h5  = (e2 + e3) >>> 1;
            res[a][0] = c_reg[a][0];
            res[a][1] = half_reg ? h1[C-1:0] : ab_reg[a];
            res[a][2] = half_reg ? h2[C-1:0] : abc_reg[a];
            res[a][3] = half_reg ? h3[C-1:0] : abcd_reg[a];
            res[a][4] = half_reg ? h4[C-1:0] : bcd_reg[a];
            res[a][5] = half_reg ? h5[C-1:0] : cd_reg[a];
            res[a][6] = c_reg[a][3];
        end
    end

    always_comb begin
        ovalid_next = ovalid_reg;
        idx_next    = idx_reg;
        if (load) begin
            ovalid_next = 1'b1;
            idx_next    = cbs_pkg::IDX_FIRST;
        end else if (m_fire) begin
            if (is_last) begin
                ovalid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= cbs_pkg::CMP_IDLE;
            level_reg  <= cbs_pkg::LVL_1;
            ovalid_reg <= 1'b0;
            idx_reg    <= cbs_pkg::IDX_FIRST;
        end else begin
            state_reg  <= state_next;
            level_reg  <= level_next;
            ovalid_reg <= ovalid_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int a = 0; a < NA; a++) begin
                for (int k = 0; k < NC; k++) begin
                    c_reg[a][k] <= q_data[(2*k+a)*C +: C];
                end
            end
            t_reg    <= q_data[8*C +: T+1];
            half_reg <= q_data[8*C+T+1];
        end
        if (state_reg == cbs_pkg::CMP_MUL) begin
            for (int a = 0; a < NA; a++) begin
                for (int l = 0; l < NL; l++) begin
                    la_reg[a][l] <= op_a[a][l];
                    lp_reg[a][l] <= prod[a][l];
                end
            end
        end
        if (state_reg == cbs_pkg::CMP_ADD) begin
            for (int a = 0; a < NA; a++) begin
                unique case (level_reg)
                    cbs_pkg::LVL_1: begin
                        ab_reg[a] <= lsum[a][0];
                        bc_reg[a] <= lsum[a][1];
                        cd_reg[a] <= lsum[a][2];
                    end
                    cbs_pkg::LVL_2: begin
                        abc_reg[a] <= lsum[a][0];
                        bcd_reg[a] <= lsum[a][1];
                    end
                    default: begin
                        abcd_reg[a] <= lsum[a][0];
                    end
                endcase
            end
        end
        if (load) begin
            for (int p = 0; p < NP; p++) begin
                ox_reg[p] <= res[0][p];
                oy_reg[p] <= res[1][p];
            end
        end else if (m_fire) begin
            for (int p = 0; p < NP - 1; p++) begin
                ox_reg[p] <= ox_reg[p+1];
                oy_reg[p] <= oy_reg[p+1];
            end
        end
    end

    assign m_valid       = ovalid_reg;
    assign m_point_index = idx_reg;
    assign m_out_x       = ox_reg[0];
    assign m_out_y       = oy_reg[0];
    assign m_last        = is_last;

endmodule

FILE: rtl/core/cubic_bezier_split.sv
// ============================================================================
// cubic_bezier_split - fixed-point cubic Bezier subdivision
// Splits a cubic curve at t and streams the seven control points of halves.
// ============================================================================
// Usage:
//   s_ channel: one request is a curve (p0..p3, signed Q16.16) and split_t
//   (Q1.16, 65536 = 1.0; larger values clamp to 1.0).
//   m_ channel: seven results per request, point_index 0..6 (start, two left
//   controls, split point, two right controls, end), last on index 6.
//   The first point of a request appears once it has passed the intake
//   register, the queue and all three lerp levels. Throughput: one point
//   per cycle while m_ready is high, set by the output channel; the three
//   lerp levels of the next curve overlap the streaming of the current one.
//   An intake register and a 2-entry queue decouple s_ from the compute
//   sequencer, so requests keep being taken while results wait.
//   When m_ready is low the current point holds; compute stops at done and
//   the queue fills, after which s_ready drops.
//   Reset (aresetn low, synchronous) empties the queue and drops m_valid.
// ============================================================================
module cubic_bezier_split #(
    parameter int COORD_BITS  = cbs_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = cbs_pkg::T_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = cbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_p0_x,
    input  logic signed [COORD_BITS-1:0]  s_p0_y,
    input  logic signed [COORD_BITS-1:0]  s_p1_x,
    input  logic signed [COORD_BITS-1:0]  s_p1_y,
    input  logic signed [COORD_BITS-1:0]  s_p2_x,
    input  logic signed [COORD_BITS-1:0]  s_p2_y,
    input  logic signed [COORD_BITS-1:0]  s_p3_x,
    input  logic signed [COORD_BITS-1:0]  s_p3_y,
    input  logic        [T_FRAC_BITS:0]   s_split_t,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cbs_pkg::IDX_BITS-1:0]  m_point_index,
    output logic signed [COORD_BITS-1:0]  m_out_x,
    output logic signed [COORD_BITS-1:0]  m_out_y,
    output logic                          m_last
);

    localparam int QW = 8 * COORD_BITS + T_FRAC_BITS + 2;

    logic          f_valid, f_ready;
    logic [QW-1:0] f_data;
    logic          b_valid, b_ready;
    logic [QW-1:0] b_data;

    cbs_front #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS),
        .QW          (QW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_p0_x    (s_p0_x),
        .s_p0_y    (s_p0_y),
        .s_p1_x    (s_p1_x),
        .s_p1_y    (s_p1_y),
        .s_p2_x    (s_p2_x),
        .s_p2_y    (s_p2_y),
        .s_p3_x    (s_p3_x),
        .s_p3_y    (s_p3_y),
        .s_split_t (s_split_t),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_data    (f_data)
    );

    cbs_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    cbs_back #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS),
        .QW          (QW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (b_valid),
        .q_ready       (b_ready),
        .q_data        (b_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_index (m_point_index),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_last        (m_last)
    );

    a_run_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=>
            (m_valid && (m_point_index == $past(m_point_index) + 3'd1)))
        else $error("result run did not advance by one point");

    a_run_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=>
            (!m_valid || (m_point_index == cbs_pkg::IDX_FIRST)))
        else $error("new run does not start at point zero");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("results pending after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_point_index) && $stable(m_out_x) && $stable(m_out_y)))
        else $error("result changed while stalled");

endmodule

FILE: test/cubic_bezier_split_test.sv
`timescale 1ns / 100ps
// ============================================================================
// cubic_bezier_split_test - self-checking bench for the Bezier splitter
// Sends curves with split_t across its full range (zero, one, one half and
// clamped values above one), predicts the seven subdivision points of each
// request and checks every point as it leaves, under random stalls on both
// channels and in back-to-back stretches.
// ============================================================================
module cubic_bezier_split_test;

    localparam int CW     = cbs_pkg::COORD_BITS_DEF;
    localparam int TW     = cbs_pkg::T_FRAC_BITS_DEF;
    localparam int IW     = cbs_pkg::IDX_BITS;
    localparam longint T_ONE  = longint'(1) << TW;
    localparam longint T_HALF = longint'(1) << (TW - 1);
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [CW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
        logic [TW:0]   t;
    } curve_t;

    typedef struct packed {
        logic [IW-1:0] idx;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } point_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [CW-1:0] s_p0_x = '0, s_p0_y = '0, s_p1_x = '0, s_p1_y = '0;
    logic signed [CW-1:0] s_p2_x = '0, s_p2_y = '0, s_p3_x = '0, s_p3_y = '0;
    logic [TW:0]          s_split_t = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [IW-1:0]        m_point_index;
    logic signed [CW-1:0] m_out_x, m_out_y;
    logic                 m_last;

    point_t pending_points[$];
    int     mismatch_count = 0;
    bit     steady = 1'b0;

    cubic_bezier_split dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_p0_x        (s_p0_x),
        .s_p0_y        (s_p0_y),
        .s_p1_x        (s_p1_x),
        .s_p1_y        (s_p1_y),
        .s_p2_x        (s_p2_x),
        .s_p2_y        (s_p2_y),
        .s_p3_x        (s_p3_x),
        .s_p3_y        (s_p3_y),
        .s_split_t     (s_split_t),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_index (m_point_index),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_last        (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("cubic_bezier_split_test failed");
        $finish;
    end

    // ---------------------------------------------------------------- model
    function automatic longint lerp_q16(longint a, longint b, longint t);
        return a + (((b - a) * t) >>> TW);
    endfunction

    function automatic longint split_coord(longint c0, longint c1, longint c2,
                                           longint c3, longint t, bit half, int k);
        longint ab, bc, cd, abc, bcd;
        if (k == 0) return c0;
        if (k == 6) return c3;
        if (half) begin
            case (k)
                1: return (c0 + c1) >>> 1;
                2: return (c0 + 2 * c1 + c2) >>> 2;
                3: return (c0 + 3 * (c1 + c2) + c3) >>> 3;
                4: return (c1 + 2 * c2 + c3) >>> 2;
                default: return (c2 + c3) >>> 1;
            endcase
        end
        ab  = lerp_q16(c0, c1, t);
        bc  = lerp_q16(c1, c2, t);
        cd  = lerp_q16(c2, c3, t);
        abc = lerp_q16(ab, bc, t);
        bcd = lerp_q16(bc, cd, t);
        case (k)
            1: return ab;
            2: return abc;
            3: return lerp_q16(abc, bcd, t);
            4: return bcd;
            default: return cd;
        endcase
    endfunction

    task automatic predict_split(input curve_t c);
        longint t;
        bit     half;
        longint vx, vy;
        point_t p;
        t = (longint'(c.t) > T_ONE) ? T_ONE : longint'(c.t);
        half = (t == T_HALF);
        for (int k = 0; k < cbs_pkg::NUM_PTS; k++) begin
            vx = split_coord($signed(c.p0x), $signed(c.p1x), $signed(c.p2x),
                             $signed(c.p3x), t, half, k);
            vy = split_coord($signed(c.p0y), $signed(c.p1y), $signed(c.p2y),
                             $signed(c.p3y), t, half, k);
            p.idx  = IW'(k);
            p.x    = vx[CW-1:0];
            p.y    = vy[CW-1:0];
            p.last = (IW'(k) == cbs_pkg::IDX_LAST);
            pending_points.push_back(p);
        end
    endtask

    // ------------------------------------------------------------- stimulus
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2, 3: return CW'($signed($urandom_range(0, 2047)) - 1024);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic [TW:0] rand_t();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return (TW+1)'(T_ONE);
            2: return (TW+1)'(T_HALF);
            3: return (TW+1)'($urandom_range(32'(T_ONE + 1), 32'(2 * T_ONE - 1)));
            default: return (TW+1)'($urandom_range(0, 32'(T_ONE)));
        endcase
    endfunction

    function automatic curve_t make_curve(logic [CW-1:0] p0x, p0y, p1x, p1y,
                                          logic [CW-1:0] p2x, p2y, p3x, p3y,
                                          logic [TW:0] t);
        curve_t c;
        c = '{p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y, t};
        return c;
    endfunction

    function automatic curve_t rand_curve(logic [TW:0] t);
        return make_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord(), t);
    endfunction

    // Valid stays high into the next request when no gap follows.
    task automatic send_curve(input curve_t c);
        int gap;
        s_valid   <= 1'b1;
        s_p0_x    <= c.p0x;
        s_p0_y    <= c.p0y;
        s_p1_x    <= c.p1x;
        s_p1_y    <= c.p1y;
        s_p2_x    <= c.p2x;
        s_p2_y    <= c.p2y;
        s_p3_x    <= c.p3x;
        s_p3_y    <= c.p3y;
        s_split_t <= c.t;
        do @(posedge aclk); while (!s_ready);
        predict_split(c);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ----------------------------------------------------------------- tests
    task automatic test_corner_curves();
        send_curve(make_curve('0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_curve(make_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                              (TW+1)'(T_ONE)));
        send_curve(make_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                              (TW+1)'(T_HALF)));
        send_curve(make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                              '0));
        send_curve(make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                              (TW+1)'(T_ONE)));
        send_curve(make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                              (TW+1)'(T_HALF)));
        send_curve(make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX,
                              (TW+1)'(T_HALF)));
        send_curve(make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX,
                              (TW+1)'(1)));
        send_curve(make_curve(C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX,
                              (TW+1)'(T_ONE - 1)));
        send_curve(make_curve(C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX,
                              (TW+1)'(T_HALF - 1)));
        send_curve(make_curve(C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX,
                              (TW+1)'(T_HALF + 1)));
        // split_t above one clamps to one
        send_curve(make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                              (TW+1)'(T_ONE + 1)));
        send_curve(make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                              '1));
        send_curve(make_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                              (TW+1)'(T_ONE + T_HALF)));
        // small negatives: floor rounding on both paths
        send_curve(make_curve(-1, -2, -3, -4, -5, -6, -7, -8, (TW+1)'(T_HALF)));
        send_curve(make_curve(-1, 2, -3, 4, -5, 6, -7, 8, (TW+1)'(21845)));
        send_curve(make_curve(0, -1, -1, 0, 1, -1, 0, 1, (TW+1)'(1)));
        send_curve(make_curve(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                              32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                              17'h0aaaa));
        send_curve(make_curve(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa,
                              32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa,
                              17'h15555));
        drain();
    endtask

    task automatic test_random_curves();
        repeat (45) send_curve(rand_curve(rand_t()));
        drain();
    endtask

    task automatic test_midpoint_split();
        repeat (20) begin
            if ($urandom_range(0, 3) == 0)
                send_curve(rand_curve((TW+1)'(T_HALF + $signed($urandom_range(0, 2)) - 1)));
            else
                send_curve(rand_curve((TW+1)'(T_HALF)));
        end
        drain();
    endtask

    task automatic test_saturated_t();
        repeat (15) send_curve(rand_curve(
            (TW+1)'($urandom_range(32'(T_ONE), 32'(2 * T_ONE - 1)))));
        drain();
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (25) send_curve(rand_curve(rand_t()));
        drain();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------- receiver
    initial begin
        int run_len;
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            run_len = $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    task automatic note_mismatch(input string what, input point_t want, input point_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%t mismatch %s: expected idx=%0d x=%h y=%h last=%b, got idx=%0d x=%h y=%h last=%b",
                     $realtime, what, want.idx, want.x, want.y, want.last,
                     got.idx, got.x, got.y, got.last);
    endtask

    always @(posedge aclk) begin
        point_t got;
        point_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_point_index, m_out_x, m_out_y, m_last};
            if (pending_points.size() == 0) begin
                note_mismatch("unexpected point", '0, got);
            end else begin
                want = pending_points.pop_front();
                if (got.idx !== want.idx) note_mismatch("point_index", want, got);
                if (got.x !== want.x) note_mismatch("out_x", want, got);
                if (got.y !== want.y) note_mismatch("out_y", want, got);
                if (got.last !== want.last) note_mismatch("last", want, got);
            end
        end
    end

    // ------------------------------------------------------------------ main
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_curves();
        test_random_curves();
        test_midpoint_split();
        test_saturated_t();
        test_back_to_back();
        if (mismatch_count == 0) begin
            $display("cubic_bezier_split_test passed");
        end else begin
            $display("cubic_bezier_split_test failed");
        end
        $finish;
    end

endmodule
